// ===== rtl/tlru_pkg.sv =====
// ----------------------------------------------------------------------------
// tlru_pkg
// Shared types and constants for the two-list LRU page replacer.
// ----------------------------------------------------------------------------
package tlru_pkg;

  localparam int FRAME_W        = 4;   // frame number width on the ports
  localparam int OP_W           = 2;
  localparam int NUM_FRAMES_DEF = 16;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TOUCH = 2'd1;
  localparam logic [OP_W-1:0] OP_EVICT = 2'd2;

  // per-list command: push frame at head, take frame out, pop tail
  typedef struct packed {
    logic push;
    logic take;
    logic pop;
  } list_cmd_t;

  typedef struct packed {
    logic               empty;
    logic [FRAME_W-1:0] tail;
  } list_stat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_found;
    logic               now_active;
    logic               now_referenced;
    logic               bad_request;
  } result_t;

endpackage

// ===== rtl/tlru_if.sv =====
// ----------------------------------------------------------------------------
// tlru_in_if / tlru_out_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface tlru_in_if;
  logic                       valid;
  logic                       ready;
  logic [tlru_pkg::OP_W-1:0]  opcode;
  logic [tlru_pkg::FRAME_W-1:0] frame;

  modport source (output valid, output opcode, output frame, input ready);
  modport sink   (input valid, input opcode, input frame, output ready);
endinterface

interface tlru_out_if;
  logic                         valid;
  logic                         ready;
  logic [tlru_pkg::FRAME_W-1:0] victim_frame;
  logic                         victim_found;
  logic                         now_active;
  logic                         now_referenced;
  logic                         bad_request;

  modport source (output valid, output victim_frame, output victim_found,
                  output now_active, output now_referenced, output bad_request,
                  input ready);
  modport sink   (input valid, input victim_frame, input victim_found,
                  input now_active, input now_referenced, input bad_request,
                  output ready);
endinterface

// ===== rtl/two_list_lru_page_replacer.sv =====
// ----------------------------------------------------------------------------
// two_list_lru_page_replacer
// Active/inactive two-list LRU replacement over NUM_FRAMES frames.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  in_ch   | in  | opcode (add/touch/evict), frame
//  out_ch  | out | victim_frame, victim_found, now_active, now_referenced,
//          |     | bad_request (one result beat per request beat)
//
//  One request per cycle sustained while out_ch does not stall; a request
//  passes the request register, then the result register. All list and
//  mark work for a request is one pass of parallel compares over the order
//  cells. rst_n is synchronous, active low: marks and list counts clear,
//  order cells are left as they are. A stalled out_ch holds the result
//  register and, once the request register is full, drops in_ch.ready.
// ----------------------------------------------------------------------------
module two_list_lru_page_replacer #(
  parameter int NUM_FRAMES = tlru_pkg::NUM_FRAMES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tlru_in_if.sink      in_ch,
  tlru_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(NUM_FRAMES+1);

  // request register
  logic                         item_v_r, item_v_nxt;
  logic [tlru_pkg::OP_W-1:0]    item_op_r;
  logic [tlru_pkg::FRAME_W-1:0] item_frame_r;

  // result register
  logic                         out_v_r, out_v_nxt;
  tlru_pkg::result_t            res_r;

  logic                 in_fire, advance;
  tlru_pkg::list_cmd_t  act_cmd, inact_cmd;
  tlru_pkg::list_stat_t act_stat, inact_stat;
  tlru_pkg::result_t    result;
  logic [CNT_W-1:0]     act_count, inact_count;

  // request moves on when the result slot is free or draining this cycle
  assign advance      = item_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !item_v_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_fire)      item_v_nxt = 1'b1;
    else if (advance) item_v_nxt = 1'b0;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance)           out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op_r    <= in_ch.opcode;
      item_frame_r <= in_ch.frame;
    end
    if (advance) begin
      res_r <= result;
    end
  end

  tlru_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .opcode     (item_op_r),
    .frame      (item_frame_r),
    .act_stat   (act_stat),
    .inact_stat (inact_stat),
    .act_cmd    (act_cmd),
    .inact_cmd  (inact_cmd),
    .result     (result)
  );

  // active list: promoted and refreshed frames
  tlru_list #(.NUM_FRAMES(NUM_FRAMES)) u_act_list (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (act_cmd),
    .frame (item_frame_r),
    .stat  (act_stat),
    .count (act_count)
  );

  // inactive list: newly added frames; victims come from its tail while it is not empty
  tlru_list #(.NUM_FRAMES(NUM_FRAMES)) u_inact_list (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (inact_cmd),
    .frame (item_frame_r),
    .stat  (inact_stat),
    .count (inact_count)
  );

  assign out_ch.valid          = out_v_r;
  assign out_ch.victim_frame   = res_r.victim_frame;
  assign out_ch.victim_found   = res_r.victim_found;
  assign out_ch.now_active     = res_r.now_active;
  assign out_ch.now_referenced = res_r.now_referenced;
  assign out_ch.bad_request    = res_r.bad_request;

  // ---- checks ----
  logic [CNT_W:0] total;
  assign total = {1'b0, act_count} + {1'b0, inact_count};

  // resident frames never outnumber the frames
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (CNT_W+1)'(NUM_FRAMES))
    else $error("list counts exceed frame count");

  // a successful evict removes exactly one resident frame
  a_evict_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.victim_found) |=> (total == $past(total) - (CNT_W+1)'(1)))
    else $error("evict did not shrink the lists by one");

  // a good add grows the lists by exactly one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (item_op_r == tlru_pkg::OP_ADD) && !result.bad_request)
      |=> (total == $past(total) + (CNT_W+1)'(1)))
    else $error("add did not grow the lists by one");

  // evict never finds a victim with both lists empty
  a_no_ghost_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (act_stat.empty && inact_stat.empty) |-> !result.victim_found)
    else $error("victim reported from empty lists");

endmodule

// ===== rtl/tlru_list.sv =====
// ----------------------------------------------------------------------------
// tlru_list
// Ordered list of frame numbers in shift cells, head at cell 0.
// ----------------------------------------------------------------------------
module tlru_list #(
  parameter int NUM_FRAMES = tlru_pkg::NUM_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlru_pkg::list_cmd_t          cmd,
  input  logic [tlru_pkg::FRAME_W-1:0] frame,
  output tlru_pkg::list_stat_t         stat,
  output logic [$clog2(NUM_FRAMES+1)-1:0] count
);

  localparam int CNT_W = $clog2(NUM_FRAMES+1);
  localparam int FW    = tlru_pkg::FRAME_W;

  logic [FW-1:0]         cells_r   [NUM_FRAMES];
  logic [FW-1:0]         cells_nxt [NUM_FRAMES];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NUM_FRAMES-1:0] match;
  logic [NUM_FRAMES-1:0] seen;     // match at or before this cell
  logic [CNT_W-1:0]      tail_idx;
  logic [FW-1:0]         tail;

  // locate the frame
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      match[i] = (CNT_W'(i) < count_r) && (cells_r[i] == frame);
      acc      = acc | match[i];
      seen[i]  = acc;
    end
  end

  always_comb begin
    tail_idx = count_r - CNT_W'(1);
    tail     = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      tail = tail | (cells_r[i] & {FW{CNT_W'(i) == tail_idx}});
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    count_nxt = count_r;
    if (cmd.push && cmd.take) begin
      // move to front: cells up to the match shift down one
      cells_nxt[0] = frame;
      for (int i = 1; i < NUM_FRAMES; i++) begin
        if (!seen[i-1]) cells_nxt[i] = cells_r[i-1];
      end
    end else if (cmd.push) begin
      cells_nxt[0] = frame;
      for (int i = 1; i < NUM_FRAMES; i++) begin
        cells_nxt[i] = cells_r[i-1];
      end
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.take) begin
      for (int i = 0; i < NUM_FRAMES - 1; i++) begin
        if (seen[i]) cells_nxt[i] = cells_r[i+1];
      end
      if (|match) count_nxt = count_r - CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.tail  = tail;
  assign count      = count_r;

endmodule

// ===== rtl/tlru_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlru_ctrl
// Per-frame marks and request decode; drives both list commands.
// ----------------------------------------------------------------------------
module tlru_ctrl #(
  parameter int NUM_FRAMES = tlru_pkg::NUM_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [tlru_pkg::OP_W-1:0]    opcode,
  input  logic [tlru_pkg::FRAME_W-1:0] frame,
  input  tlru_pkg::list_stat_t         act_stat,
  input  tlru_pkg::list_stat_t         inact_stat,
  output tlru_pkg::list_cmd_t          act_cmd,
  output tlru_pkg::list_cmd_t          inact_cmd,
  output tlru_pkg::result_t            result
);

  localparam int CNT_W = $clog2(NUM_FRAMES+1);
  localparam int CMP_W = (CNT_W > tlru_pkg::FRAME_W) ? CNT_W : tlru_pkg::FRAME_W;

  logic [NUM_FRAMES-1:0] res_r, res_nxt;
  logic [NUM_FRAMES-1:0] act_r, act_nxt;
  logic [NUM_FRAMES-1:0] ref_r, ref_nxt;
  logic [NUM_FRAMES-1:0] sel, vsel;
  logic                  ok, res_hit, act_hit, ref_hit;
  logic [tlru_pkg::FRAME_W-1:0] victim;
  tlru_pkg::list_cmd_t   act_c, inact_c;

  assign ok     = CMP_W'(frame) < CMP_W'(NUM_FRAMES);
  assign victim = inact_stat.empty ? act_stat.tail : inact_stat.tail;

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      sel[i]  = ok && (CMP_W'(frame) == CMP_W'(i));
      vsel[i] = (CMP_W'(victim) == CMP_W'(i));
    end
  end

  assign res_hit = |(res_r & sel);
  assign act_hit = |(act_r & sel);
  assign ref_hit = |(ref_r & sel);

  always_comb begin
    res_nxt = res_r;
    act_nxt = act_r;
    ref_nxt = ref_r;
    act_c   = '0;
    inact_c = '0;
    result  = '0;
    case (opcode)
      tlru_pkg::OP_ADD: begin
        if (!ok) begin
          result.bad_request = 1'b1;
        end else if (res_hit) begin
          result.bad_request    = 1'b1;
          result.now_active     = act_hit;
          result.now_referenced = ref_hit;
        end else begin
          res_nxt      = res_r | sel;
          act_nxt      = act_r & ~sel;
          ref_nxt      = ref_r & ~sel;
          inact_c.push = 1'b1;
        end
      end
      tlru_pkg::OP_TOUCH: begin
        if (!ok || !res_hit) begin
          result.bad_request = 1'b1;
        end else if (act_hit) begin
          // refresh within the active list
          act_c.push            = 1'b1;
          act_c.take            = 1'b1;
          result.now_active     = 1'b1;
          result.now_referenced = ref_hit;
        end else if (ref_hit) begin
          // second reference: promote
          inact_c.take      = 1'b1;
          act_c.push        = 1'b1;
          act_nxt           = act_r | sel;
          ref_nxt           = ref_r & ~sel;
          result.now_active = 1'b1;
        end else begin
          ref_nxt               = ref_r | sel;
          result.now_referenced = 1'b1;
        end
      end
      tlru_pkg::OP_EVICT: begin
        // with no inactive frames the active tail is demoted and
        // taken at once, so it leaves straight from the active list
        if (!inact_stat.empty || !act_stat.empty) begin
          if (!inact_stat.empty) inact_c.pop = 1'b1;
          else                   act_c.pop   = 1'b1;
          res_nxt             = res_r & ~vsel;
          act_nxt             = act_r & ~vsel;
          ref_nxt             = ref_r & ~vsel;
          result.victim_frame = victim;
          result.victim_found = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign act_cmd   = fire ? act_c   : '0;
  assign inact_cmd = fire ? inact_c : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
      act_r <= '0;
      ref_r <= '0;
    end else if (fire) begin
      res_r <= res_nxt;
      act_r <= act_nxt;
      ref_r <= ref_nxt;
    end
  end

endmodule

// ===== bench/lru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_checker
// Watches request and result beats of the two-list LRU replacer, keeps its
// own copy of the lists and marks, and compares each result beat in order.
// ----------------------------------------------------------------------------
module lru_checker (
  input  logic clk,
  input  logic rst_n,
  tlru_in_if   req,
  tlru_out_if  res,
  output int   fail_count,
  output int   pending
);

  localparam int NF = tlru_pkg::NUM_FRAMES_DEF;
  localparam int FW = tlru_pkg::FRAME_W;

  bit                  resident  [NF];
  bit                  is_active [NF];
  bit                  refd      [NF];
  logic [FW-1:0]       act_order_q[$];    // head at index 0, tail at the end
  logic [FW-1:0]       inact_order_q[$];
  tlru_pkg::result_t   expected_results[$];
  tlru_pkg::result_t   want;

  function automatic tlru_pkg::result_t predict_replace(logic [tlru_pkg::OP_W-1:0] op,
                                                        logic [FW-1:0] f);
    tlru_pkg::result_t r;
    int                pos[$];
    logic [FW-1:0]     d;
    r = '0;
    case (op)
      tlru_pkg::OP_ADD: begin
        if (resident[f]) begin
          r.bad_request    = 1'b1;
          r.now_active     = is_active[f];
          r.now_referenced = refd[f];
        end else begin
          resident[f]  = 1'b1;
          is_active[f] = 1'b0;
          refd[f]      = 1'b0;
          inact_order_q.push_front(f);
        end
      end
      tlru_pkg::OP_TOUCH: begin
        if (!resident[f]) begin
          r.bad_request = 1'b1;
        end else begin
          if (!is_active[f]) begin
            if (refd[f]) begin
              // second touch while inactive: promote
              pos = inact_order_q.find_first_index(item) with (item == f);
              inact_order_q.delete(pos[0]);
              is_active[f] = 1'b1;
              refd[f]      = 1'b0;
              act_order_q.push_front(f);
            end else begin
              refd[f] = 1'b1;
            end
          end else begin
            pos = act_order_q.find_first_index(item) with (item == f);
            act_order_q.delete(pos[0]);
            act_order_q.push_front(f);
          end
          r.now_active     = is_active[f];
          r.now_referenced = refd[f];
        end
      end
      tlru_pkg::OP_EVICT: begin
        if (inact_order_q.size() == 0 && act_order_q.size() > 0) begin
          d = act_order_q.pop_back();
          is_active[d] = 1'b0;
          refd[d]      = 1'b0;
          inact_order_q.push_front(d);
        end
        if (inact_order_q.size() > 0) begin
          d = inact_order_q.pop_back();
          resident[d]    = 1'b0;
          is_active[d]   = 1'b0;
          refd[d]        = 1'b0;
          r.victim_frame = d;
          r.victim_found = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        resident[i]  = 1'b0;
        is_active[i] = 1'b0;
        refd[i]      = 1'b0;
      end
      act_order_q.delete();
      inact_order_q.delete();
      expected_results.delete();
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(predict_replace(req.opcode, req.frame));
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res.victim_frame !== want.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", want.victim_frame, res.victim_frame);
            fail_count++;
          end
          if (res.victim_found !== want.victim_found) begin
            $error("victim_found: expected %0d, got %0d", want.victim_found, res.victim_found);
            fail_count++;
          end
          if (res.now_active !== want.now_active) begin
            $error("now_active: expected %0d, got %0d", want.now_active, res.now_active);
            fail_count++;
          end
          if (res.now_referenced !== want.now_referenced) begin
            $error("now_referenced: expected %0d, got %0d",
                   want.now_referenced, res.now_referenced);
            fail_count++;
          end
          if (res.bad_request !== want.bad_request) begin
            $error("bad_request: expected %0d, got %0d", want.bad_request, res.bad_request);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request beats into the two-list LRU replacer with random gaps and
// result back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OPW = tlru_pkg::OP_W;
  localparam int FW  = tlru_pkg::FRAME_W;

  // opcode 3 has no meaning; the block must answer it with an all-zero beat
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_BEATS = 1750;
  // ~1800 beats, each with its worst-case gap, stall and latency, with lots of room
  localparam int CYCLE_LIMIT  = 200000;

  // request mix, switched every few dozen beats
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   src_burst;   // sender runs back to back while set
  bit   snk_burst;   // receiver never stalls while set

  tlru_in_if  req_if();
  tlru_out_if res_if();

  two_list_lru_page_replacer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  lru_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request beat. The gap is taken before valid rises; with no gap the
  // valid stays high from the previous beat, so it is never dropped and
  // raised in the same step.
  task automatic send_req(logic [OPW-1:0] op, logic [FW-1:0] fr);
    int gap;
    gap = src_burst ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.frame  <= fr;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Result side: a random stall before each beat, same rule for ready.
  initial begin
    int stall;
    int taken;
    taken = 0;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0)
        snk_burst = ($urandom_range(0, 3) == 0);
      stall = snk_burst ? 0 : int'($urandom_range(0, 7));
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      taken++;
    end
  end

  initial begin
    int             sent;
    int             draws;
    int             roll;
    int             add_cut;
    int             touch_cut;
    int             evict_cut;
    bit             hot;
    mix_t           mix;
    logic [OPW-1:0] op;
    logic [FW-1:0]  fr;

    sent      = 0;
    draws     = 0;
    hot       = 1'b0;
    mix       = MIX_FILL;
    src_burst = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= tlru_pkg::OP_ADD;
    req_if.frame  <= '0;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_req(tlru_pkg::OP_EVICT, 4'd0);     // both lists empty: no victim
    send_req(tlru_pkg::OP_ADD, 4'd0);
    send_req(tlru_pkg::OP_ADD, 4'd15);
    send_req(tlru_pkg::OP_ADD, 4'd0);       // already resident: flagged, marks echoed
    send_req(tlru_pkg::OP_TOUCH, 4'd9);     // not resident: flagged
    send_req(tlru_pkg::OP_TOUCH, 4'd15);    // inactive, sets referenced
    send_req(tlru_pkg::OP_TOUCH, 4'd15);    // inactive + referenced: promote
    send_req(tlru_pkg::OP_TOUCH, 4'd0);
    send_req(tlru_pkg::OP_TOUCH, 4'd0);     // promote, now active head
    send_req(tlru_pkg::OP_TOUCH, 4'd15);    // active: move back to head
    send_req(tlru_pkg::OP_ADD, 4'd15);      // resident and active: flagged
    send_req(OP_UNUSED, 4'd15);             // unused opcode: all zero
    send_req(tlru_pkg::OP_ADD, 4'd10);
    send_req(tlru_pkg::OP_EVICT, 4'd15);    // inactive tail goes
    send_req(tlru_pkg::OP_EVICT, 4'd0);     // inactive empty: active tail demoted, then out
    send_req(tlru_pkg::OP_EVICT, 4'd0);
    send_req(tlru_pkg::OP_EVICT, 4'd0);     // empty again
    send_req(tlru_pkg::OP_TOUCH, 4'd15);    // evicted frame no longer resident

    // ---- random part ----
    // Fill phases build up full lists, churn phases drive referenced marks
    // and promotions (often on a small hot set), drain phases walk the
    // demotion path and empty the lists.
    while (sent < RANDOM_BEATS) begin
      if (draws % 64 == 0) begin
        mix       = mix_t'($urandom_range(0, 2));
        hot       = ($urandom_range(0, 1) == 1);
        src_burst = ($urandom_range(0, 3) == 0);
      end
      draws++;
      case (mix)
        MIX_FILL: begin
          add_cut = 55; touch_cut = 85; evict_cut = 97;
        end
        MIX_CHURN: begin
          add_cut = 15; touch_cut = 78; evict_cut = 98;
        end
        default: begin
          add_cut = 10; touch_cut = 35; evict_cut = 98;
        end
      endcase
      roll = int'($urandom_range(0, 99));
      if (roll < add_cut)
        op = tlru_pkg::OP_ADD;
      else if (roll < touch_cut)
        op = tlru_pkg::OP_TOUCH;
      else if (roll < evict_cut)
        op = tlru_pkg::OP_EVICT;
      else
        op = OP_UNUSED;
      if (op == tlru_pkg::OP_TOUCH && hot)
        fr = FW'($urandom_range(0, 3));
      else
        fr = FW'($urandom_range(0, 15));
      send_req(op, fr);
      if (op != OP_UNUSED)
        sent++;
    end
    req_if.valid <= 1'b0;

    // pending is updated through a register, so step before trusting it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
